// File: hdl/hbsf_pkg.sv
// Package with the shared types, codes and widths of the bond stretching force block.
package hbsf_pkg;

	// Product width of the digit-serial multiplier.
	localparam int PW = 88;

	// Saturation value of the 48-bit energy sum.
	localparam logic [47:0] E_MAX = 48'hFFFF_FFFF_FFFF;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_CAP  = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ,
		S_SQRT,
		S_DLT,
		S_DSQ,
		S_EN,
		S_GK,
		S_DIV,
		S_GU,
		S_EMIT0,
		S_EMIT1,
		S_EMIT2
	} state_t;

endpackage

// File: hdl/hbsf_mul.sv
// Digit-serial unsigned multiplier, 52 by 48 bits, one 16-bit digit per cycle.
module hbsf_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [51:0]             a,
	input  logic [47:0]             b,
	output logic [hbsf_pkg::PW-1:0] prod,
	output logic                    done
);
	import hbsf_pkg::*;

	logic [51:0]   a_q;
	logic [47:0]   b_q;
	logic [PW-1:0] acc_q;
	logic [1:0]    cnt_q;
	logic          done_q;
	logic [67:0]   part;

	// Partial product of the operand with the top digit.
	assign part = a_q * b_q[47:32];

	// Control: digit counter and finish strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 2'd3;
			done_q <= 1'b0;
		end else if (cnt_q != 2'd0) begin
			cnt_q  <= cnt_q - 2'd1;
			done_q <= (cnt_q == 2'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: shift the accumulator one digit and add the partial product.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (cnt_q != 2'd0) begin
			acc_q <= {acc_q[PW-17:0], 16'b0} + PW'(part);
			b_q   <= {b_q[31:0], 16'b0};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// File: hdl/hbsf_divsqrt.sv
// Shared restoring unit: integer square root of a 68-bit word or the quotient |a| * 2^30 / d.
module hbsf_divsqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_sqrt,
	input  logic [67:0] op_a,
	input  logic [33:0] divisor,
	output logic [33:0] result,
	output logic        done
);
	import hbsf_pkg::*;

	logic [67:0] n_q;
	logic [37:0] rem_q;
	logic [33:0] root_q;
	logic [5:0]  cnt_q;
	logic        sqrt_q;
	logic        done_q;
	logic [37:0] rem_sh;
	logic [37:0] trial;
	logic        ge;

	// One step: bring in the next bits, compare with the trial value and subtract.
	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q[35:0], n_q[67:66]};
			trial  = {2'b00, root_q, 2'b01};
		end else begin
			rem_sh = {rem_q[36:0], n_q[67]};
			trial  = {4'b0000, divisor};
		end
		ge = (rem_sh >= trial);
	end

	// Control: step counter and finish strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 6'd0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= is_sqrt ? 6'd34 : 6'd31;
			done_q <= 1'b0;
		end else if (cnt_q != 6'd0) begin
			cnt_q  <= cnt_q - 6'd1;
			done_q <= (cnt_q == 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath. The quotient is below 2^31, so division starts with the top bits preloaded.
	always_ff @(posedge clk) begin
		if (start) begin
			sqrt_q <= is_sqrt;
			root_q <= '0;
			if (is_sqrt) begin
				n_q   <= op_a;
				rem_q <= '0;
			end else begin
				n_q   <= {op_a[0], 67'b0};
				rem_q <= 38'(op_a[32:1]);
			end
		end else if (cnt_q != 6'd0) begin
			n_q    <= sqrt_q ? {n_q[65:0], 2'b00} : {n_q[66:0], 1'b0};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[32:0], ge};
		end
	end

	assign result = root_q;
	assign done   = done_q;

endmodule

// File: hdl/harmonic_bond_stretch_force.sv
// Bond stretching force over a streamed chain of particles: sequencer, state and memory.
// Items are taken one at a time: in_stall is high while the sequencer works on an item,
// so a new particle is accepted only in idle. A force item emits a word, and on a chain's
// end a second word, both of which any output stall can delay. The work is done by the
// bit-serial square root and divider and the 16-bit-digit multiplier under one sequencer.
// Reset clears chain state, carries and energy sum and sets stiffness to 1.0, not the memory.
module harmonic_bond_stretch_force #(
	parameter int MAX_BONDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] stiffness,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic        chain_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] particle_index,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic [47:0] energy_total,
	output logic [1:0]  status,
	output logic        final_result
);
	import hbsf_pkg::*;

	localparam int CW = $clog2(MAX_BONDS + 1);
	localparam int AW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;

	state_t state_q, state_d;

	// Control state.
	logic [31:0]        k_q;
	logic               have_prev_q;
	logic [CW-1:0]      bcnt_q;
	logic signed [31:0] prev_q [3];
	logic signed [31:0] carry_q [3];
	logic [47:0]        esum_q;
	logic               pend_q, pend_d;
	logic [1:0]         ax_q;
	logic               out_valid_q;

	// Item data.
	logic               mode_q, end_q, oob_q, sat_q, dpos_q;
	logic [CW-1:0]      b_q;
	logic [32:0]        adx_q [3];
	logic               ndx_q [3];
	logic [65:0]        sum_q;
	logic [33:0]        d_q;
	logic [33:0]        adl_q;
	logic [51:0]        sq_q;
	logic [50:0]        g_q;
	logic [30:0]        u_q;
	logic signed [31:0] f_q [3];
	logic [31:0]        rest_q;

	// Output word.
	logic [10:0]        oidx_q;
	logic signed [31:0] of_q [3];
	logic [47:0]        oen_q;
	logic [1:0]         ost_q;
	logic               ofin_q;

	// Rest length memory.
	logic [31:0] mem [MAX_BONDS];

	// Unit connections.
	logic        mul_start, mul_done, ds_start, ds_done;
	logic [51:0] mul_a;
	logic [47:0] mul_b;
	logic [PW-1:0] prod;
	logic        ds_sqrt;
	logic [67:0] ds_a;
	logic [33:0] ds_res;

	logic in_acc, can_load, load_out, d0;
	logic [1:0] st;
	logic signed [31:0] fb [3];
	logic signed [32:0] net [3];
	logic ovf;
	logic [CW-1:0] i2;
	logic signed [32:0] diff [3];
	logic signed [34:0] delta;
	logic [48:0] esum_add;
	logic [47:0] e_val;
	logic [50:0] m_val;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign d0        = (d_q == 34'd0);

	// Shared arithmetic units.
	hbsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	hbsf_divsqrt u_ds (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ds_start),
		.is_sqrt (ds_sqrt),
		.op_a    (ds_a),
		.divisor (d_q),
		.result  (ds_res),
		.done    (ds_done)
	);

	// Position differences against the previous particle.
	always_comb begin
		diff[0] = {prev_q[0][31], prev_q[0]} - {pos_x[31], pos_x};
		diff[1] = {prev_q[1][31], prev_q[1]} - {pos_y[31], pos_y};
		diff[2] = {prev_q[2][31], prev_q[2]} - {pos_z[31], pos_z};
	end

	// Stretch, energy term and force magnitude from the current product.
	always_comb begin
		delta    = {1'b0, d_q} - {3'b000, rest_q};
		e_val    = (|prod[87:64]) ? E_MAX : prod[63:16];
		esum_add = {1'b0, esum_q} + {1'b0, e_val};
		m_val    = prod[80:30];
	end

	// Bond status and the net force on the earlier particle.
	always_comb begin
		if (oob_q)
			st = ST_CAP;
		else if (d0)
			st = ST_ZERO;
		else if (sat_q)
			st = ST_SAT;
		else
			st = ST_OK;
		ovf = 1'b0;
		for (int i = 0; i < 3; i++) begin
			fb[i]  = (st == ST_OK) ? f_q[i] : 32'sd0;
			net[i] = {carry_q[i][31], carry_q[i]} + {fb[i][31], fb[i]};
			ovf    = ovf | (net[i][32] != net[i][31]);
		end
		i2 = oob_q ? b_q : b_q + CW'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (!have_prev_q)
						state_d = (mode && chain_end) ? S_EMIT0 : S_IDLE;
					else
						state_d = S_SQ;
				end
			end
			S_SQ:    if (mul_done && ax_q == 2'd2) state_d = S_SQRT;
			S_SQRT:  if (ds_done) state_d = S_DLT;
			S_DLT: begin
				if (!mode_q)
					state_d = S_IDLE;
				else if (oob_q)
					state_d = S_EMIT1;
				else
					state_d = S_DSQ;
			end
			S_DSQ:   if (mul_done) state_d = S_EN;
			S_EN:    if (mul_done) state_d = S_GK;
			S_GK:    if (mul_done) state_d = d0 ? S_EMIT1 : S_DIV;
			S_DIV:   if (ds_done) state_d = S_GU;
			S_GU:    if (mul_done) state_d = (ax_q == 2'd2) ? S_EMIT1 : S_DIV;
			S_EMIT0: if (can_load) state_d = S_IDLE;
			S_EMIT1: if (can_load) state_d = end_q ? S_EMIT2 : S_IDLE;
			S_EMIT2: if (can_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		pend_d = (state_d != state_q) || (state_q == S_SQ && mul_done && ax_q != 2'd2);
	end

	// Unit starts, operand selection and output loads.
	always_comb begin
		mul_start = 1'b0;
		ds_start  = 1'b0;
		ds_sqrt   = 1'b0;
		ds_a      = {35'b0, adx_q[ax_q]};
		mul_a     = 52'(adx_q[ax_q]);
		mul_b     = 48'(adx_q[ax_q]);
		load_out  = 1'b0;
		unique case (state_q)
			S_SQ:   mul_start = pend_q;
			S_SQRT: begin
				ds_start = pend_q;
				ds_sqrt  = 1'b1;
				ds_a     = {2'b00, sum_q};
			end
			S_DSQ: begin
				mul_start = pend_q;
				mul_a     = 52'(adl_q);
				mul_b     = 48'(adl_q);
			end
			S_EN: begin
				mul_start = pend_q;
				mul_a     = sq_q;
				mul_b     = 48'(k_q);
			end
			S_GK: begin
				mul_start = pend_q;
				mul_a     = 52'(adl_q);
				mul_b     = 48'(k_q);
			end
			S_DIV:  ds_start = pend_q;
			S_GU: begin
				mul_start = pend_q;
				mul_a     = 52'(g_q);
				mul_b     = 48'(u_q);
			end
			S_EMIT0, S_EMIT1, S_EMIT2: load_out = can_load;
			default: ;
		endcase
	end

	// Control registers and chain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			ax_q        <= 2'd0;
			k_q         <= 32'h0001_0000;
			have_prev_q <= 1'b0;
			bcnt_q      <= '0;
			esum_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i]  <= '0;
				carry_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (cfg_valid)
				k_q <= stiffness;
			if (in_acc) begin
				ax_q      <= 2'd0;
				prev_q[0] <= pos_x;
				prev_q[1] <= pos_y;
				prev_q[2] <= pos_z;
				if (!have_prev_q) begin
					have_prev_q <= !chain_end;
					bcnt_q      <= '0;
					esum_q      <= '0;
					for (int i = 0; i < 3; i++)
						carry_q[i] <= '0;
				end else begin
					if (bcnt_q < CW'(MAX_BONDS))
						bcnt_q <= bcnt_q + CW'(1);
					if (chain_end)
						have_prev_q <= 1'b0;
				end
			end
			if ((state_q == S_SQ || state_q == S_GU) && mul_done && ax_q != 2'd2)
				ax_q <= ax_q + 2'd1;
			if (state_q == S_GK && mul_done)
				ax_q <= 2'd0;
			if (state_q == S_EN && mul_done)
				esum_q <= esum_add[48] ? E_MAX : esum_add[47:0];
			if (state_q == S_EMIT1 && can_load) begin
				for (int i = 0; i < 3; i++)
					carry_q[i] <= -fb[i];
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			end_q  <= chain_end;
			b_q    <= bcnt_q;
			oob_q  <= (bcnt_q >= CW'(MAX_BONDS));
			sat_q  <= 1'b0;
			sum_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				ndx_q[i] <= diff[i][32];
				adx_q[i] <= diff[i][32] ? -diff[i] : diff[i];
			end
		end
		if (state_q == S_SQ && mul_done)
			sum_q <= sum_q + prod[65:0];
		if (state_q == S_SQRT && ds_done)
			d_q <= ds_res;
		if (state_q == S_DLT) begin
			dpos_q <= !delta[34] && (delta != 35'sd0);
			adl_q  <= delta[34] ? 34'(-delta) : delta[33:0];
		end
		if (state_q == S_DSQ && mul_done)
			sq_q <= prod[67:16];
		if (state_q == S_GK && mul_done)
			g_q <= prod[65:15];
		if (state_q == S_DIV && ds_done)
			u_q <= ds_res[30:0];
		if (state_q == S_GU && mul_done) begin
			if (|prod[87:61]) begin
				sat_q       <= 1'b1;
				f_q[ax_q]   <= '0;
			end else if (dpos_q ^ ndx_q[ax_q]) begin
				f_q[ax_q] <= -$signed({1'b0, m_val[30:0]});
			end else begin
				f_q[ax_q] <= $signed({1'b0, m_val[30:0]});
			end
		end
	end

	// Rest length memory: written in capture mode, read data registered.
	always_ff @(posedge clk) begin
		if (state_q == S_DLT && !mode_q && !oob_q)
			mem[b_q[AW-1:0]] <= (|d_q[33:32]) ? 32'hFFFF_FFFF : d_q[31:0];
		rest_q <= mem[b_q[AW-1:0]];
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			oen_q <= esum_q;
			unique case (state_q)
				S_EMIT1: begin
					oidx_q <= 11'(b_q);
					ost_q  <= ovf ? ST_SAT : st;
					ofin_q <= 1'b0;
					for (int i = 0; i < 3; i++)
						of_q[i] <= ovf ? 32'sd0 : net[i][31:0];
				end
				S_EMIT2: begin
					oidx_q <= 11'(i2);
					ost_q  <= st;
					ofin_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						of_q[i] <= carry_q[i];
				end
				default: begin
					oidx_q <= 11'd0;
					ost_q  <= ST_OK;
					ofin_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						of_q[i] <= '0;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign particle_index = oidx_q;
	assign force_x        = of_q[0];
	assign force_y        = of_q[1];
	assign force_z        = of_q[2];
	assign energy_total   = oen_q;
	assign status         = ost_q;
	assign final_result   = ofin_q;

endmodule

// File: test/hbsf_checker.sv
// Checker for the bond stretching force block: predicts each result word and compares it.
`timescale 1ns / 100ps

module hbsf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] stiffness,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic        chain_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [10:0] particle_index,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic [47:0] energy_total,
	input  logic [1:0]  status,
	input  logic        final_result,
	output int          fails,
	output int          pending
);
	import hbsf_pkg::*;

	localparam int BOND_CAP = 1024;

	typedef struct {
		logic [10:0] idx;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
		logic [47:0] energy;
		logic [1:0]  st;
		logic        fin;
	} force_word_t;

	force_word_t expected_words[$];

	// Shadow of the block's state.
	logic [31:0] k_reg;
	logic signed [31:0] px, py, pz;
	bit chain_open;
	int bonds;
	logic [31:0] rest_mem [BOND_CAP];
	longint cx, cy, cz;
	logic [47:0] esum;

	function automatic bit fits32(longint v);
		return v >= -64'sd2147483648 && v <= 64'sd2147483647;
	endfunction

	// One component of a bond force, rounded toward zero; flags saturation.
	function automatic longint bond_part(logic [63:0] g, longint dv, logic [33:0] d,
			longint dlt, inout bit sat);
		logic [63:0] amag, u, m;
		amag = dv < 0 ? -dv : dv;
		u = (amag << 30) / 64'(d);
		m = 64'((128'(g) * 128'(u)) >> 30);
		if (m > 64'h7FFF_FFFF) begin
			sat = 1'b1;
			return 0;
		end
		return ((dlt > 0) != (dv < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic void push_word(logic [10:0] idx, longint fx, longint fy, longint fz,
			logic [1:0] st, logic fin);
		force_word_t w;
		w.idx = idx;
		w.fx = fx[31:0];
		w.fy = fy[31:0];
		w.fz = fz[31:0];
		w.energy = esum;
		w.st = st;
		w.fin = fin;
		expected_words.push_back(w);
	endfunction

	// Advance the shadow state by one particle and queue the words it causes.
	task automatic track_particle(logic m, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic last);
		longint dx, dy, dz, dlt, nx, ny, nz, fx, fy, fz;
		logic [32:0] ax, ay, az;
		logic [67:0] ss, cw;
		logic [33:0] d, c;
		logic [63:0] dm, sq, g;
		logic [127:0] p;
		logic [47:0] e;
		logic [48:0] esum_w;
		logic [1:0] st, st1;
		bit sat;
		int b, i2;
		b = bonds;
		if (!chain_open) begin
			px = x; py = y; pz = z;
			chain_open = !last;
			bonds = 0;
			cx = 0; cy = 0; cz = 0;
			esum = '0;
			if (last && m)
				push_word(11'd0, 0, 0, 0, ST_OK, 1'b1);
			return;
		end
		dx = longint'(px) - longint'(x);
		dy = longint'(py) - longint'(y);
		dz = longint'(pz) - longint'(z);
		ax = 33'(dx < 0 ? -dx : dx);
		ay = 33'(dy < 0 ? -dy : dy);
		az = 33'(dz < 0 ? -dz : dz);
		ss = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay) + 68'(az) * 68'(az);
		// Bit-by-bit integer square root.
		d = '0;
		for (int i = 33; i >= 0; i--) begin
			c = d | (34'd1 << i);
			cw = 68'(c);
			if (cw * cw <= ss)
				d = c;
		end
		fx = 0; fy = 0; fz = 0;
		st = ST_OK;
		if (!m) begin
			if (b < BOND_CAP)
				rest_mem[b] = (d > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
		end else begin
			if (b >= BOND_CAP) begin
				st = ST_CAP;
			end else begin
				dlt = longint'(d) - longint'(rest_mem[b]);
				dm = dlt < 0 ? -dlt : dlt;
				p = 128'(dm) * 128'(dm);
				sq = 64'(p >> 16);
				p = (128'(k_reg) * 128'(sq)) >> 16;
				e = (p > 128'(E_MAX)) ? E_MAX : p[47:0];
				esum_w = 49'(esum) + 49'(e);
				esum = (esum_w > 49'(E_MAX)) ? E_MAX : esum_w[47:0];
				if (d == 0) begin
					st = ST_ZERO;
				end else begin
					sat = 1'b0;
					g = 64'((128'(k_reg) * 128'(dm)) >> 15);
					fx = bond_part(g, dx, d, dlt, sat);
					fy = bond_part(g, dy, d, dlt, sat);
					fz = bond_part(g, dz, d, dlt, sat);
					if (sat) begin
						st = ST_SAT;
						fx = 0; fy = 0; fz = 0;
					end
				end
			end
			nx = cx + fx; ny = cy + fy; nz = cz + fz;
			st1 = st;
			if (!fits32(nx) || !fits32(ny) || !fits32(nz)) begin
				st1 = ST_SAT;
				nx = 0; ny = 0; nz = 0;
			end
			push_word(11'(b), nx, ny, nz, st1, 1'b0);
			cx = -fx; cy = -fy; cz = -fz;
			if (last) begin
				i2 = (b + 1 > BOND_CAP) ? BOND_CAP : b + 1;
				push_word(11'(i2), cx, cy, cz, st, 1'b1);
			end
		end
		px = x; py = y; pz = z;
		if (b < BOND_CAP)
			bonds = b + 1;
		if (last)
			chain_open = 1'b0;
	endtask

	// Watch the three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		force_word_t w;
		bit bad;
		if (!arst_n) begin
			k_reg = 32'h0001_0000;
			px = '0; py = '0; pz = '0;
			chain_open = 1'b0;
			bonds = 0;
			cx = 0; cy = 0; cz = 0;
			esum = '0;
			expected_words.delete();
			fails = 0;
			pending = 0;
		end else begin
			// Compare a delivered word with the oldest expectation.
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected word: index %0d force %h %h %h", particle_index,
							force_x, force_y, force_z);
				end else begin
					w = expected_words.pop_front();
					bad = particle_index !== w.idx || force_x !== w.fx || force_y !== w.fy
						|| force_z !== w.fz || energy_total !== w.energy
						|| status !== w.st || final_result !== w.fin;
					if (bad) begin
						fails++;
						if (fails <= 10)
							$display({"mismatch: exp idx %0d f %h %h %h e %h st %0d fin %b",
								" / got idx %0d f %h %h %h e %h st %0d fin %b"},
								w.idx, w.fx, w.fy, w.fz, w.energy, w.st, w.fin,
								particle_index, force_x, force_y, force_z, energy_total,
								status, final_result);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				k_reg = stiffness;
			if (in_valid && !in_stall)
				track_particle(mode, pos_x, pos_y, pos_z, chain_end);
			pending = expected_words.size();
		end
	end

endmodule

// File: test/tb_harmonic_bond_stretch_force.sv
// Testbench top for the bond stretching force block: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_harmonic_bond_stretch_force;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] stiffness;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic        chain_end;
	logic        out_valid;
	logic        out_stall;
	logic [10:0] particle_index;
	logic signed [31:0] force_x, force_y, force_z;
	logic [47:0] energy_total;
	logic [1:0]  status;
	logic        final_result;
	int          fails;
	int          pending;

	bit calm;
	int sent;
	logic signed [31:0] walk_x, walk_y, walk_z;

	harmonic_bond_stretch_force dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .stiffness(stiffness),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .chain_end(chain_end),
		.out_valid(out_valid), .out_stall(out_stall), .particle_index(particle_index),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.energy_total(energy_total), .status(status), .final_result(final_result)
	);

	hbsf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .stiffness(stiffness),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .chain_end(chain_end),
		.out_valid(out_valid), .out_stall(out_stall), .particle_index(particle_index),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.energy_total(energy_total), .status(status), .final_result(final_result),
		.fails(fails), .pending(pending)
	);

	// Clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver stalls at random outside calm stretches.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 18);
	end

	// Send one particle word, with an optional idle gap first. The word stays valid after
	// acceptance until the next call replaces it or the sender drains.
	task automatic send_particle(logic m, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic last);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 18) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 200) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		chain_end <= last;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Hold off until every expected word has come and the block has settled.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_stiffness(logic [31:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		stiffness <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Next coordinate of a random walk, with occasional wild or extreme values.
	function automatic logic signed [31:0] step_coord(logic signed [31:0] p);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom;
		if (r < 12)
			return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		return p + $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
	endfunction

	// A chain of n particles; a mixed chain picks the mode per particle, otherwise the
	// particles from index force_from on are sent in force mode.
	task automatic run_chain(logic m, int n, bit mixed, int force_from);
		logic mm;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) >= 8) begin
				walk_x = step_coord(walk_x);
				walk_y = step_coord(walk_y);
				walk_z = step_coord(walk_z);
			end
			mm = mixed ? 1'($urandom_range(0, 1)) : ((i >= force_from) ? 1'b1 : m);
			send_particle(mm, walk_x, walk_y, walk_z, i == n - 1);
		end
	endtask

	initial begin
		logic [31:0] k_pick;
		int chains;
		int len;
		cfg_valid = 1'b0;
		stiffness = '0;
		in_valid = 1'b0;
		mode = 1'b0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		chain_end = 1'b0;
		calm = 1'b0;
		sent = 0;
		walk_x = '0; walk_y = '0; walk_z = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Single-particle chains in both modes.
		send_particle(1'b1, 0, 0, 0, 1'b1);
		send_particle(1'b0, 1, 2, 3, 1'b1);
		// Capture a chain with extreme jumps and a zero-length bond.
		send_particle(1'b0, 0, 0, 0, 1'b0);
		send_particle(1'b0, 32'sh1_0000, 0, 0, 1'b0);
		send_particle(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_particle(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_particle(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_particle(1'b0, 0, 32'sh3_0000, -32'sh4_0000, 1'b1);
		// The same chain in force mode, one bond stretched.
		send_particle(1'b1, 0, 0, 0, 1'b0);
		send_particle(1'b1, 32'sh1_8000, 0, 0, 1'b0);
		send_particle(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_particle(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_particle(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_particle(1'b1, 0, 32'sh3_0000, -32'sh4_0000, 1'b1);
		// Largest stiffness with a huge stretch saturates the bond force.
		write_stiffness(32'hFFFF_FFFF);
		send_particle(1'b1, 0, 0, 0, 1'b0);
		send_particle(1'b1, 32'sh7FFF_FFFF, 0, 32'sh10, 1'b0);
		send_particle(1'b1, 32'sh7FFF_FFF0, 5, 32'sh10, 1'b1);
		write_stiffness(32'h0);
		send_particle(1'b1, 0, 0, 0, 1'b0);
		send_particle(1'b1, 32'sh2_0000, 0, 0, 1'b1);

		// Fill every rest length, capture one bond past capacity, then run past capacity
		// in force mode at the end of the same chain.
		write_stiffness(32'h0002_8000);
		run_chain(1'b0, 1028, 1'b0, 1026);

		// Random short chains.
		chains = 0;
		while (sent < 1250) begin
			if (chains % 8 == 7) begin
				case ($urandom_range(0, 4))
					0: k_pick = 32'h0;
					1: k_pick = 32'hFFFF_FFFF;
					2: k_pick = 32'h0001_0000;
					3: k_pick = $urandom_range(0, 32'h0010_0000);
					default: k_pick = $urandom;
				endcase
				write_stiffness(k_pick);
			end
			calm = (chains >= 8 && chains < 16);
			len = $urandom_range(1, 12);
			if ($urandom_range(0, 9) == 0)
				run_chain(1'b0, len, 1'b1, len);
			else
				run_chain($urandom_range(0, 9) < 7, len, 1'b0, len);
			chains++;
		end
		calm = 1'b0;

		wait_drained();
		if (fails == 0 && pending == 0)
			$display("tb_harmonic_bond_stretch_force OK");
		else
			$display("tb_harmonic_bond_stretch_force NOT OK");
		$finish;
	end

	// Watchdog.
	initial begin
		#30_000_000;
		$display("tb_harmonic_bond_stretch_force NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
hdl/hbsf_pkg.sv
hdl/hbsf_mul.sv
hdl/hbsf_divsqrt.sv
hdl/harmonic_bond_stretch_force.sv
test/hbsf_checker.sv
test/tb_harmonic_bond_stretch_force.sv
